### sv/aete_pkg.sv
// Package with the types, codes and helper functions of the alignment event tag encoder.
package aete_pkg;

  localparam logic [2:0] KIND_MATCH    = 3'd0;
  localparam logic [2:0] KIND_MISMATCH = 3'd1;
  localparam logic [2:0] KIND_INSERT   = 3'd2;
  localparam logic [2:0] KIND_DELETE   = 3'd3;
  localparam logic [2:0] KIND_CLIP     = 3'd4;

  localparam logic [2:0] OP_M = 3'd0;
  localparam logic [2:0] OP_I = 3'd1;
  localparam logic [2:0] OP_D = 3'd2;
  localparam logic [2:0] OP_S = 3'd4;

  localparam logic [1:0] RK_CIGAR = 2'd0;
  localparam logic [1:0] RK_MD    = 2'd1;
  localparam logic [1:0] RK_NM    = 2'd2;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_CARET = 8'h5E;

  localparam int unsigned LEN_FIELD_W = 16;
  localparam int unsigned NM_W        = 16;
  localparam int unsigned BCD_DIGITS  = 5;
  localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
  localparam int unsigned IDX_W       = $clog2(BCD_DIGITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHG,
    S_NUM,
    S_SYM,
    S_BASE,
    S_FINW,
    S_NM
  } aete_state_e;

  typedef struct packed {
    logic load;
    logic take;
  } aete_dec_ctrl_t;

  typedef struct packed {
    logic       digit_valid;
    logic [3:0] digit;
    logic       last_digit;
  } aete_dec_stat_t;

  function automatic logic [7:0] base_letter(input logic [1:0] base);
    logic [7:0] ch;
    case (base)
      2'd0:    ch = 8'h41;
      2'd1:    ch = 8'h43;
      2'd2:    ch = 8'h47;
      default: ch = 8'h54;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] op_of(input logic [2:0] kind);
    logic [2:0] op;
    case (kind)
      KIND_MATCH, KIND_MISMATCH: op = OP_M;
      KIND_INSERT:               op = OP_I;
      KIND_DELETE:               op = OP_D;
      default:                   op = OP_S;
    endcase
    return op;
  endfunction

endpackage

### sv/aete_if.sv
// Handshake interfaces for the event input and the result output of the tag encoder.
interface aete_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [1:0] ref_base;
  logic       last_event;

  modport source (output valid, output event_kind, output ref_base, output last_event,
                  input ready);
  modport sink (input valid, input event_kind, input ref_base, input last_event,
                output ready);
endinterface

interface aete_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [19:0] cigar_word;
  logic [7:0]  md_char;
  logic [15:0] edit_distance;
  logic        last;

  modport source (output valid, output result_kind, output cigar_word, output md_char,
                  output edit_distance, output last, input ready);
  modport sink (input valid, input result_kind, input cigar_word, input md_char,
                input edit_distance, input last, output ready);
endinterface

### sv/alignment_event_tag_encoder.sv
// Top level of the alignment event tag encoder: CIGAR words, MD text and NM from events.
//
//   Channel  Direction  Handshake          Contents
//   in_i     sink       valid/ready        event_kind, ref_base, last_event
//   out_o    source     valid/ready        result_kind, cigar_word, md_char,
//                                          edit_distance, last
//
// A match or insertion that neither changes the CIGAR operation nor ends the read
// is taken without a result. A decimal count of W = min(RUN_WIDTH, 16) bits comes from
// the shared serial decimal converter: it shifts in one bit per cycle, then walks its
// five digits one per cycle, skips leading zeros and holds a shown digit until taken.
// The end of a read adds the final word, the closing count and the NM result.
// Reset clears all counters; any cycle with out_o.ready low holds the current result.
module alignment_event_tag_encoder #(
  parameter int unsigned RUN_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aete_in_if.sink    in_i,
  aete_out_if.source out_o
);
  import aete_pkg::*;

  localparam int unsigned CW = (RUN_WIDTH < LEN_FIELD_W) ? RUN_WIDTH : LEN_FIELD_W;

  aete_state_e    state_q, state_d;
  aete_dec_ctrl_t dec_ctrl;
  aete_dec_stat_t dec_stat;

  logic [2:0]      prev_op_q;
  logic            have_prev_q;
  logic [CW-1:0]   run_q;
  logic [CW-1:0]   md_run_q;
  logic            in_del_q;
  logic [NM_W-1:0] diff_q;
  logic            mism_q, del_q, num_q, fin_q, fin_phase_q;
  logic [1:0]      base_q;
  logic [19:0]     chg_word_q;
  logic [CW-1:0]   num_val_q;
  logic [CW-1:0]   dec_value;

  logic [2:0] kind;
  logic [2:0] op;
  logic       is_match, is_mism, is_ins, is_del, del_start, need_num, chg;
  logic       in_acc, out_hs, out_valid;

  assign kind      = (in_i.event_kind > KIND_CLIP) ? KIND_CLIP : in_i.event_kind;
  assign op        = op_of(kind);
  assign is_match  = (kind == KIND_MATCH);
  assign is_mism   = (kind == KIND_MISMATCH);
  assign is_ins    = (kind == KIND_INSERT);
  assign is_del    = (kind == KIND_DELETE);
  assign del_start = is_del && !in_del_q;
  assign need_num  = is_mism || del_start;
  assign chg       = have_prev_q && (op != prev_op_q);

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid;
  assign out_hs     = out_valid && out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (chg) begin
            state_d = S_CHG;
          end else if (need_num) begin
            state_d = S_NUM;
          end else if (is_del) begin
            state_d = S_BASE;
          end else if (in_i.last_event) begin
            state_d = S_FINW;
          end
        end
      end
      S_CHG: begin
        if (out_hs) begin
          if (num_q) begin
            state_d = S_NUM;
          end else if (del_q) begin
            state_d = S_BASE;
          end else if (fin_q) begin
            state_d = S_FINW;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_NUM: begin
        if (out_hs && dec_stat.last_digit) begin
          state_d = fin_phase_q ? S_NM : S_SYM;
        end
      end
      S_SYM: begin
        if (out_hs) begin
          if (del_q) begin
            state_d = S_BASE;
          end else if (fin_q) begin
            state_d = S_FINW;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_BASE: begin
        if (out_hs) begin
          state_d = fin_q ? S_FINW : S_IDLE;
        end
      end
      S_FINW: begin
        if (out_hs) begin
          state_d = S_NUM;
        end
      end
      S_NM: begin
        if (out_hs) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid           = 1'b0;
    out_o.result_kind   = RK_CIGAR;
    out_o.cigar_word    = '0;
    out_o.md_char       = '0;
    out_o.edit_distance = '0;
    out_o.last          = 1'b0;
    dec_ctrl.load       = 1'b0;
    dec_ctrl.take       = 1'b0;
    dec_value           = num_val_q;
    case (state_q)
      S_IDLE: begin
        dec_value     = md_run_q;
        dec_ctrl.load = in_acc && !chg && need_num;
      end
      S_CHG: begin
        out_valid        = 1'b1;
        out_o.cigar_word = chg_word_q;
        dec_ctrl.load    = out_hs && num_q;
      end
      S_NUM: begin
        out_valid         = dec_stat.digit_valid;
        out_o.result_kind = RK_MD;
        out_o.md_char     = ASCII_ZERO + {4'd0, dec_stat.digit};
        dec_ctrl.take     = out_hs;
      end
      S_SYM: begin
        out_valid         = 1'b1;
        out_o.result_kind = RK_MD;
        out_o.md_char     = del_q ? ASCII_CARET : base_letter(base_q);
      end
      S_BASE: begin
        out_valid         = 1'b1;
        out_o.result_kind = RK_MD;
        out_o.md_char     = base_letter(base_q);
      end
      S_FINW: begin
        out_valid        = 1'b1;
        out_o.cigar_word = {LEN_FIELD_W'(run_q), 1'b0, prev_op_q};
        dec_value        = md_run_q;
        dec_ctrl.load    = out_hs;
      end
      S_NM: begin
        out_valid           = 1'b1;
        out_o.result_kind   = RK_NM;
        out_o.edit_distance = diff_q;
        out_o.last          = 1'b1;
      end
      default: out_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_op_q   <= OP_M;
      have_prev_q <= 1'b0;
      run_q       <= '0;
      md_run_q    <= '0;
      in_del_q    <= 1'b0;
      diff_q      <= '0;
      mism_q      <= 1'b0;
      del_q       <= 1'b0;
      num_q       <= 1'b0;
      fin_q       <= 1'b0;
      fin_phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        prev_op_q   <= op;
        have_prev_q <= 1'b1;
        if (chg) begin
          run_q <= CW'(1);
        end else if (run_q != '1) begin
          run_q <= run_q + 1'b1;
        end
        if (is_match) begin
          if (md_run_q != '1) begin
            md_run_q <= md_run_q + 1'b1;
          end
        end else if (need_num) begin
          md_run_q <= '0;
        end
        if (is_match || is_mism) begin
          in_del_q <= 1'b0;
        end else if (is_del) begin
          in_del_q <= 1'b1;
        end
        if ((is_mism || is_ins || is_del) && (diff_q != '1)) begin
          diff_q <= diff_q + 1'b1;
        end
        mism_q      <= is_mism;
        del_q       <= is_del;
        num_q       <= need_num;
        fin_q       <= in_i.last_event;
        fin_phase_q <= 1'b0;
      end else if ((state_q == S_FINW) && out_hs) begin
        fin_phase_q <= 1'b1;
      end else if ((state_q == S_NM) && out_hs) begin
        prev_op_q   <= OP_M;
        have_prev_q <= 1'b0;
        run_q       <= '0;
        md_run_q    <= '0;
        in_del_q    <= 1'b0;
        diff_q      <= '0;
        fin_phase_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_q     <= in_i.ref_base;
      chg_word_q <= {LEN_FIELD_W'(run_q), 1'b0, prev_op_q};
      num_val_q  <= md_run_q;
    end
  end

  aete_dec_serial #(
    .VAL_WIDTH(CW)
  ) u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dec_ctrl),
    .value_i(dec_value),
    .stat_o (dec_stat)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid)
    else $error("An event was taken while a result was offered.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_o.result_kind == RK_CIGAR)) |-> (out_o.cigar_word[19:4] != '0))
    else $error("A CIGAR word with a zero run length was offered.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_NM) && out_hs) |=> (diff_q == '0) && !have_prev_q && (run_q == '0))
    else $error("Read state was not cleared after the edit distance transaction.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_stat.digit_valid && (state_q == S_NUM)) |-> (dec_stat.digit <= 4'd9))
    else $error("The decimal converter produced a digit above nine.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SYM) && out_hs) |-> (mism_q || del_q))
    else $error("A symbol was sent for an event that is neither mismatch nor deletion.");

endmodule

### sv/aete_dec_serial.sv
// Bit-serial binary to decimal converter that hands out digits one per cycle while they are taken.
module aete_dec_serial #(
  parameter int unsigned VAL_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  aete_pkg::aete_dec_ctrl_t ctrl_i,
  input  logic [VAL_WIDTH-1:0]     value_i,
  output aete_pkg::aete_dec_stat_t stat_o
);
  import aete_pkg::*;

  localparam int unsigned CNT_W = $clog2(VAL_WIDTH + 1);

  logic [VAL_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [BCD_W-1:0]     adj;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 seen_q, seen_d;
  logic                 conv_q, conv_d;
  logic                 emit_q, emit_d;
  logic [3:0]           top;
  logic                 show;

  assign top  = bcd_q[BCD_W-1 -: 4];
  assign show = (top != 4'd0) || seen_q || (idx_q == '0);

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    seen_d = seen_q;
    conv_d = conv_q;
    emit_d = emit_q;
    if (ctrl_i.load) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = CNT_W'(VAL_WIDTH);
      conv_d = 1'b1;
      emit_d = 1'b0;
    end else if (conv_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VAL_WIDTH-1]};
      bin_d = {bin_q[VAL_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        conv_d = 1'b0;
        emit_d = 1'b1;
        idx_d  = IDX_W'(BCD_DIGITS - 1);
        seen_d = 1'b0;
      end
    end else if (emit_q && (!show || ctrl_i.take)) begin
      bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
      idx_d = idx_q - 1'b1;
      if (show) begin
        seen_d = 1'b1;
      end
      if (idx_q == '0) begin
        emit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= 1'b0;
      emit_q <= 1'b0;
      cnt_q  <= '0;
      idx_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      conv_q <= conv_d;
      emit_q <= emit_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.digit_valid = emit_q && show;
  assign stat_o.digit       = top;
  assign stat_o.last_digit  = (idx_q == '0);

endmodule
